FILE: rtl/core/fpc_pkg.sv
`timescale 1ns / 1ps

package fpc_pkg;

  // fixed word and plane geometry
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned PLANE_COUNT = 6;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // request codes
  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_TEST    = 2'd2
  } req_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EX_RDW,
    ST_EX_RDR,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_T_INIT,
    ST_T_MUL,
    ST_T_ACC,
    ST_T_CMP,
    ST_T_OUT
  } state_e;

  // handshake between sequencer and divider
  typedef struct packed {
    logic             start;
    logic [WORD_W-1:0] num_mag;
    logic [WORD_W-1:0] den;
  } div_req_t;

endpackage

FILE: rtl/core/fpc_div.sv
`timescale 1ns / 1ps

// restoring divider, (num_mag << FRAC_BITS) / den, one quotient bit per cycle
module fpc_div #(
  parameter int unsigned FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fpc_pkg::div_req_t                     req_i,
  output logic                                  done_o,
  output logic [fpc_pkg::WORD_W+FRAC_BITS-1:0]  quot_o
);

  localparam int unsigned W   = fpc_pkg::WORD_W;
  localparam int unsigned NW  = W + FRAC_BITS;
  localparam int unsigned CW  = $clog2(NW + 1);

  logic [NW-1:0] n_q, n_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [W:0]    rem_sh;
  logic          ge;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, n_q[NW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    n_d    = n_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      n_d   = {req_i.num_mag, {FRAC_BITS{1'b0}}};
      rem_d = '0;
      den_d = req_i.den;
      cnt_d = CW'(NW);
    end else if (cnt_q != '0) begin
      rem_d = ge ? W'(rem_sh - {1'b0, den_q}) : rem_sh[W-1:0];
      n_d   = {n_q[NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule

FILE: rtl/core/frustum_plane_extract_and_sphere_cull.sv
`timescale 1ns / 1ps

// channel   direction  ports                                      beat
// request   in         start, busy, req_type_i .. sphere_radius_i start && !busy
// result    out        result_valid_o, inside_res_o               result_valid_o
//
// a matrix write is taken on accept and leaves busy low
// an extract takes per plane 8 element reads, squares of the first three terms,
// 32 square root steps and 4 divisions, all on one sequencer
// a sphere test runs all 6 planes through the single 32x32 multiplier, then
// a one-cycle result strobe; the receiver cannot stall, the strobe lasts one cycle
// reset clears both matrix and planes at once; request code 3 is dropped
module frustum_plane_extract_and_sphere_cull #(
  parameter int unsigned FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  element_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0] sphere_radius_i,
  output logic        result_valid_o,
  output logic        inside_res_o
);

  localparam int unsigned W  = fpc_pkg::WORD_W;
  localparam int unsigned NW = W + FRAC_BITS;
  localparam int unsigned PC = fpc_pkg::PLANE_COUNT;

  fpc_pkg::state_e state_q, state_d;

  logic signed [W-1:0] mat_q [16];
  logic signed [W-1:0] pl_q  [PC*4];
  logic signed [W-1:0] p_q   [4];
  logic signed [W-1:0] c_q   [3];

  logic [2:0]  plane_q, plane_d;
  logic [1:0]  k_q, k_d;
  logic signed [W-1:0] rdw_q;
  logic signed [63:0]  prod_q;
  logic [63:0] s_q, res_q, bit_q;
  logic signed [63:0]  acc_q;
  logic [30:0] rad_q;
  logic        fail_q;

  logic        accept;
  logic signed [W-1:0] mat_rd, pl_rd, op_a, op_b;
  logic signed [W:0]   pre;
  logic signed [W-1:0] pre_sat;
  logic [63:0] trial;
  logic [W-1:0] len;
  logic [W-1:0] mag;
  logic         neg;
  logic signed [W-1:0] div_sat;
  logic signed [63:0]  neg_rad;

  fpc_pkg::div_req_t div_req;
  logic              div_done;
  logic [NW-1:0]     quot;

  assign accept = start && !busy;
  assign busy   = state_q != fpc_pkg::ST_IDLE;
  assign len    = res_q[W-1:0];

  // element and plane read ports, one address each
  assign mat_rd = (state_q == fpc_pkg::ST_EX_RDW) ? mat_q[{k_q, 2'b11}]
                                                  : mat_q[{k_q, plane_q[2:1]}];
  assign pl_rd  = (state_q == fpc_pkg::ST_T_INIT) ? pl_q[5'({plane_q, 2'b11})]
                                                  : pl_q[5'({plane_q, k_q})];

  // saturating row sum or difference
  always_comb begin
    pre = plane_q[0] ? ({rdw_q[W-1], rdw_q} - {mat_rd[W-1], mat_rd})
                     : ({rdw_q[W-1], rdw_q} + {mat_rd[W-1], mat_rd});
    if (pre[W] != pre[W-1]) begin
      pre_sat = pre[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      pre_sat = pre[W-1:0];
    end
  end

  // shared multiplier operands
  always_comb begin
    if (state_q == fpc_pkg::ST_T_MUL) begin
      op_a = pl_rd;
      op_b = c_q[k_q];
    end else begin
      op_a = p_q[k_q];
      op_b = p_q[k_q];
    end
  end

  // square root trial
  assign trial = res_q + bit_q;

  // divider hookup and saturation of the signed quotient
  always_comb begin
    neg = p_q[k_q][W-1];
    mag = neg ? W'(~p_q[k_q] + 1'b1) : p_q[k_q];
    div_req.start   = (state_q == fpc_pkg::ST_DIV_START) && (len != '0);
    div_req.num_mag = mag;
    div_req.den     = len;
    if (!neg) begin
      div_sat = (quot > NW'(64'h7FFF_FFFF)) ? {1'b0, {(W-1){1'b1}}} : quot[W-1:0];
    end else begin
      div_sat = (quot > NW'(64'h8000_0000)) ? {1'b1, {(W-1){1'b0}}}
                                            : W'(~quot[W-1:0] + 1'b1);
    end
  end

  assign neg_rad = -$signed({33'd0, rad_q});

  fpc_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    plane_d = plane_q;
    k_d     = k_q;
    case (state_q)
      fpc_pkg::ST_IDLE: begin
        plane_d = '0;
        k_d     = '0;
        if (accept && req_type_i == fpc_pkg::REQ_EXTRACT) begin
          state_d = fpc_pkg::ST_EX_RDW;
        end else if (accept && req_type_i == fpc_pkg::REQ_TEST) begin
          state_d = fpc_pkg::ST_T_INIT;
        end
      end
      fpc_pkg::ST_EX_RDW: state_d = fpc_pkg::ST_EX_RDR;
      fpc_pkg::ST_EX_RDR: begin
        k_d = k_q + 1'b1;
        state_d = (k_q == 2'd3) ? fpc_pkg::ST_SQ_MUL : fpc_pkg::ST_EX_RDW;
      end
      fpc_pkg::ST_SQ_MUL: state_d = fpc_pkg::ST_SQ_ACC;
      fpc_pkg::ST_SQ_ACC: begin
        if (k_q == 2'd2) begin
          k_d = '0;
          state_d = fpc_pkg::ST_SQRT;
        end else begin
          k_d = k_q + 1'b1;
          state_d = fpc_pkg::ST_SQ_MUL;
        end
      end
      fpc_pkg::ST_SQRT: begin
        if (bit_q[0]) begin
          state_d = fpc_pkg::ST_DIV_START;
        end
      end
      fpc_pkg::ST_DIV_START, fpc_pkg::ST_DIV_WAIT: begin
        if ((state_q == fpc_pkg::ST_DIV_START && len == '0) ||
            (state_q == fpc_pkg::ST_DIV_WAIT && div_done)) begin
          k_d = k_q + 1'b1;
          if (k_q != 2'd3) begin
            state_d = fpc_pkg::ST_DIV_START;
          end else if (plane_q == 3'(PC - 1)) begin
            state_d = fpc_pkg::ST_IDLE;
          end else begin
            plane_d = plane_q + 1'b1;
            state_d = fpc_pkg::ST_EX_RDW;
          end
        end else begin
          state_d = fpc_pkg::ST_DIV_WAIT;
        end
      end
      fpc_pkg::ST_T_INIT: begin
        k_d = '0;
        state_d = fpc_pkg::ST_T_MUL;
      end
      fpc_pkg::ST_T_MUL: state_d = fpc_pkg::ST_T_ACC;
      fpc_pkg::ST_T_ACC: begin
        k_d = k_q + 1'b1;
        state_d = (k_q == 2'd2) ? fpc_pkg::ST_T_CMP : fpc_pkg::ST_T_MUL;
      end
      fpc_pkg::ST_T_CMP: begin
        if (plane_q == 3'(PC - 1)) begin
          state_d = fpc_pkg::ST_T_OUT;
        end else begin
          plane_d = plane_q + 1'b1;
          state_d = fpc_pkg::ST_T_INIT;
        end
      end
      fpc_pkg::ST_T_OUT: state_d = fpc_pkg::ST_IDLE;
      default: state_d = fpc_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpc_pkg::ST_IDLE;
      plane_q <= '0;
      k_q     <= '0;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      plane_q <= plane_d;
      k_q     <= k_d;
      if (accept) begin
        fail_q <= 1'b0;
      end else if (state_q == fpc_pkg::ST_T_CMP && acc_q < neg_rad) begin
        fail_q <= 1'b1;
      end
    end
  end

  // matrix and plane stores, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
      for (int i = 0; i < PC*4; i++) pl_q[i] <= '0;
    end else begin
      if (accept && req_type_i == fpc_pkg::REQ_WRITE) begin
        mat_q[element_index_i] <= element_value_i;
      end
      if (state_q == fpc_pkg::ST_DIV_START && len == '0) begin
        pl_q[5'({plane_q, k_q})] <= p_q[k_q];
      end else if (state_q == fpc_pkg::ST_DIV_WAIT && div_done) begin
        pl_q[5'({plane_q, k_q})] <= div_sat;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q[0] <= center_x_i;
      c_q[1] <= center_y_i;
      c_q[2] <= center_z_i;
      rad_q  <= sphere_radius_i;
    end
    case (state_q)
      fpc_pkg::ST_EX_RDW: rdw_q <= mat_rd;
      fpc_pkg::ST_EX_RDR: begin
        p_q[k_q] <= pre_sat;
        s_q      <= '0;
      end
      fpc_pkg::ST_SQ_MUL, fpc_pkg::ST_T_MUL: prod_q <= op_a * op_b;
      fpc_pkg::ST_SQ_ACC: begin
        s_q <= s_q + prod_q;
        if (k_q == 2'd2) begin
          res_q <= '0;
          bit_q <= 64'd1 << 62;
        end
      end
      fpc_pkg::ST_SQRT: begin
        if (s_q >= trial) begin
          s_q   <= s_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      fpc_pkg::ST_T_INIT: acc_q <= 64'(pl_rd);
      fpc_pkg::ST_T_ACC: acc_q <= acc_q + (prod_q >>> FRAC_BITS);
      default: ;
    endcase
  end

  assign result_valid_o = state_q == fpc_pkg::ST_T_OUT;
  assign inside_res_o   = !fail_q;

  // checks
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == fpc_pkg::REQ_TEST) |=> busy)
    else $error("test request did not occupy the sequencer");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == fpc_pkg::ST_DIV_WAIT)
    else $error("divider finished outside a division wait");

endmodule
